// ===== hw/rtl/klbe_pkg.sv =====
// Shared types and constants of the K-line block link engine.
package klbe_pkg;

	localparam int unsigned TIMEOUT_RESET = 1000;
	localparam int unsigned MAX_LEN_RESET = 64;
	localparam int unsigned QUEUE_DEPTH   = 2;

	localparam logic [7:0] BYTE_IDLE  = 8'hFF;
	localparam logic [7:0] SYNC_BYTE0 = 8'h55;
	localparam logic [7:0] SYNC_BYTE1 = 8'h01;
	localparam logic [7:0] SYNC_BYTE2 = 8'h8A;

	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_MAX_LEN = 1'b1;

	typedef enum logic [2:0] {
		KIND_RX_BYTE    = 3'd0,
		KIND_TX_BYTE    = 3'd1,
		KIND_TICK       = 3'd2,
		KIND_SYNC       = 3'd3,
		KIND_DISCONNECT = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_NONE    = 3'd0,
		ST_BLOCK   = 3'd1,
		ST_SYNC    = 3'd2,
		ST_TIMEOUT = 3'd3,
		ST_DATA    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE, PH_SYNC, PH_READY, PH_RECV, PH_WAIT_ACK, PH_SEND_MID
	} phase_t;

	// Classified operation handed from the front to the back.
	typedef enum logic [2:0] {
		OP_NOP, OP_LINE, OP_SEND, OP_TICK, OP_START, OP_DROP
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       rx_last;
		logic [2:0] status;
		logic       link_up;
		logic [7:0] block_count;
		logic [15:0] timeout_errors;
		logic [15:0] data_errors;
	} result_t;

endpackage

// ===== hw/rtl/klbe_front.sv =====
// Front end: takes input beats, classifies them and queues the commands.
module klbe_front import klbe_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] kind,
	input  logic [7:0] data,
	input  logic       last,
	output logic       cmd_valid,
	input  logic       cmd_take,
	output cmd_t       cmd
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	cmd_t          cls;
	logic          push, pop;

	always_comb begin
		cls.data = data;
		cls.last = last;
		unique case (kind)
			KIND_RX_BYTE:    cls.op = (data == BYTE_IDLE) ? OP_NOP : OP_LINE;
			KIND_TX_BYTE:    cls.op = OP_SEND;
			KIND_TICK:       cls.op = OP_TICK;
			KIND_SYNC:       cls.op = OP_START;
			KIND_DISCONNECT: cls.op = OP_DROP;
			default:         cls.op = OP_NOP;
		endcase
	end

	assign in_stall  = (cnt_q == (AW+1)'(DEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

// ===== hw/rtl/klbe_back.sv =====
// Back end: link state machine, counters and the registered result beat.
module klbe_back import klbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_take,
	input  cmd_t        cmd,
	input  logic [15:0] timeout_ms,
	input  logic [7:0]  max_block_len,
	output logic        res_valid,
	input  logic        res_stall,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic        link_q, link_d, skip_q, skip_d;
	logic [7:0]  ctr_q, ctr_d, pend_q, pend_d;
	logic [8:0]  size_q, size_d, idx_q, idx_d;
	logic [15:0] sil_q, sil_d, tto_q, tto_d, tdat_q, tdat_d;
	result_t     r;
	logic        fire, valid_q;
	result_t     res_q;
	logic [8:0]  i, ni;
	logic [15:0] sil_inc, tmo;
	logic [7:0]  sync_exp;

	assign cmd_take  = cmd_valid && (!valid_q || !res_stall);
	assign fire      = cmd_take;
	assign res_valid = valid_q;
	assign res       = res_q;

	always_comb begin
		phase_d = phase_q; link_d = link_q; skip_d = skip_q; ctr_d = ctr_q;
		pend_d = pend_q; size_d = size_q; idx_d = idx_q; sil_d = sil_q;
		tto_d = tto_q; tdat_d = tdat_q;
		r = '0;
		i = '0; ni = '0;
		sil_inc = sil_q + ((sil_q != 16'hFFFF) ? 16'd1 : 16'd0);
		tmo = (timeout_ms == '0) ? 16'd1 : timeout_ms;
		unique case (idx_q[1:0])
			2'd0:    sync_exp = SYNC_BYTE0;
			2'd1:    sync_exp = SYNC_BYTE1;
			default: sync_exp = SYNC_BYTE2;
		endcase
		unique case (cmd.op)
			OP_LINE: begin
				sil_d = '0;
				if (skip_q) begin
					skip_d = 1'b0;
				end else if (phase_q == PH_SYNC) begin
					if (idx_q > 9'd2 || cmd.data != sync_exp) begin
						r.status = ST_DATA;
					end else if (idx_q == 9'd2) begin
						r.tx_valid = 1'b1; r.tx_byte = ~cmd.data; skip_d = 1'b1;
						link_d = 1'b1; phase_d = PH_READY; idx_d = '0; r.status = ST_SYNC;
					end else begin
						idx_d = idx_q + 9'd1;
					end
				end else if (phase_q == PH_READY || phase_q == PH_RECV) begin
					i  = (phase_q == PH_READY) ? 9'd0 : idx_q;
					ni = i + 9'd1;
					if ((i == 9'd0 && ({1'b0, cmd.data} + 9'd1) > {1'b0, max_block_len})
					    || (i == 9'd1 && cmd.data != ctr_q)) begin
						r.status = ST_DATA;
					end else begin
						if (i == 9'd0) size_d = {1'b0, cmd.data} + 9'd1;
						r.rx_valid = 1'b1; r.rx_byte = cmd.data;
						if (ni >= size_d) begin
							r.rx_last = 1'b1; ctr_d = ctr_q + 8'd1; phase_d = PH_READY;
							idx_d = '0; r.status = ST_BLOCK;
						end else begin
							idx_d = ni; phase_d = PH_RECV; r.tx_valid = 1'b1;
							r.tx_byte = ~cmd.data; skip_d = 1'b1;
						end
					end
				end else if (phase_q == PH_WAIT_ACK) begin
					if (cmd.data == ~pend_q) phase_d = PH_SEND_MID;
					else r.status = ST_DATA;
				end
			end
			OP_SEND: begin
				if (phase_q == PH_READY || phase_q == PH_SEND_MID) begin
					r.tx_valid = 1'b1; r.tx_byte = cmd.data; skip_d = 1'b1;
					if (cmd.last) begin
						ctr_d = ctr_q + 8'd1; phase_d = PH_READY; idx_d = '0;
						r.status = ST_BLOCK;
					end else begin
						pend_d = cmd.data; phase_d = PH_WAIT_ACK; sil_d = '0;
					end
				end
			end
			OP_TICK: begin
				if (phase_q == PH_SYNC || phase_q == PH_RECV || phase_q == PH_WAIT_ACK) begin
					sil_d = sil_inc;
					if (sil_inc >= tmo) begin
						r.status = ST_TIMEOUT;
						if (tto_q != 16'hFFFF) tto_d = tto_q + 16'd1;
					end
				end
			end
			OP_START: begin
				phase_d = PH_SYNC; link_d = 1'b0; skip_d = 1'b0; idx_d = '0;
				sil_d = '0; ctr_d = '0;
			end
			OP_DROP: begin
				phase_d = PH_IDLE; link_d = 1'b0; skip_d = 1'b0; idx_d = '0; sil_d = '0;
			end
			default: ;
		endcase
		// A data or timeout fault drops the link.
		if (r.status == ST_DATA || r.status == ST_TIMEOUT) begin
			phase_d = PH_IDLE; link_d = 1'b0; skip_d = 1'b0; idx_d = '0; sil_d = '0;
			if (r.status == ST_DATA && tdat_q != 16'hFFFF) tdat_d = tdat_q + 16'd1;
		end
		r.link_up = link_d; r.block_count = ctr_d;
		r.timeout_errors = tto_d; r.data_errors = tdat_d;
	end

	always_ff @(posedge clk) begin
		if (fire) res_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; link_q <= 1'b0; skip_q <= 1'b0; ctr_q <= '0;
			pend_q <= '0; size_q <= '0; idx_q <= '0; sil_q <= '0;
			tto_q <= '0; tdat_q <= '0; valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_d; link_q <= link_d; skip_q <= skip_d; ctr_q <= ctr_d;
				pend_q <= pend_d; size_q <= size_d; idx_q <= idx_d; sil_q <= sil_d;
				tto_q <= tto_d; tdat_q <= tdat_d;
			end
			if (fire) valid_q <= 1'b1;
			else if (!res_stall) valid_q <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/kline_block_link_engine_top.sv =====
// Top level of the K-line block link engine.
// The engine runs the byte-level block link: it syncs on 0x55 0x01 0x8A, receives and sends
// blocks with complement acknowledges, drops echoes of its own bytes and the idle byte 0xFF,
// and counts timeout and data errors. Each input beat yields exactly one result beat. A beat
// passes a front classifier into a two-entry command queue; the back end does one state update
// per cycle unless the output stalls, so one beat is taken each clock when nothing stalls;
// a beat is held in the queue, then its result in the output register. Configuration writes
// are always ready and should be made only while the engine is idle.
module kline_block_link_engine_top import klbe_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [7:0]  data,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        rx_valid,
	output logic [7:0]  rx_byte,
	output logic        rx_last,
	output logic [2:0]  status,
	output logic        link_up,
	output logic [7:0]  block_count,
	output logic [15:0] timeout_errors,
	output logic [15:0] data_errors
);

	logic [15:0] timeout_q;
	logic [7:0]  max_len_q;
	logic        cmd_valid, cmd_take;
	cmd_t        cmd;
	result_t     res;

	assign cfg_ready = 1'b1;

	// Register file: the index port is one bit, as there are only two registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 16'(TIMEOUT_RESET);
			max_len_q <= 8'(MAX_LEN_RESET);
		end else if (cfg_valid) begin
			if (cfg_index == CFG_TIMEOUT) timeout_q <= cfg_data;
			if (cfg_index == CFG_MAX_LEN) max_len_q <= cfg_data[7:0];
		end
	end

	klbe_front #(.DEPTH(DEPTH)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .kind, .data, .last,
		.cmd_valid, .cmd_take, .cmd
	);

	klbe_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd,
		.timeout_ms(timeout_q), .max_block_len(max_len_q),
		.res_valid(out_valid), .res_stall(out_stall), .res
	);

	assign tx_valid       = res.tx_valid;
	assign tx_byte        = res.tx_byte;
	assign rx_valid       = res.rx_valid;
	assign rx_byte        = res.rx_byte;
	assign rx_last        = res.rx_last;
	assign status         = res.status;
	assign link_up        = res.link_up;
	assign block_count    = res.block_count;
	assign timeout_errors = res.timeout_errors;
	assign data_errors    = res.data_errors;

endmodule
